>>> hdl/rcsr_pkg.sv
package rcsr_pkg;

  // default channel width and fixed field widths
  localparam int unsigned WidthBitsDef = 12;
  localparam int unsigned NumCh        = 4;
  localparam int unsigned NumBnd       = 8;
  localparam int unsigned ThrW         = 12;
  localparam int unsigned HoldW        = 16;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned PhaseW       = 4;
  localparam int unsigned SlotW        = 3;
  localparam int unsigned ValW         = 9;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 16;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgNeutralThr  = 2'd0,
    CfgNeutralHold = 2'd1,
    CfgExtremeHold = 2'd2
  } cfg_idx_e;

  // configuration reset values
  localparam logic [ThrW-1:0]  NeutralThrRst  = 12'd3;
  localparam logic [HoldW-1:0] NeutralHoldRst = 16'd10000;
  localparam logic [HoldW-1:0] ExtremeHoldRst = 16'd7000;

  // calibration phase codes
  localparam logic [PhaseW-1:0] PhaseIdle  = 4'd0;
  localparam logic [PhaseW-1:0] PhaseFirst = 4'd1;
  localparam logic [PhaseW-1:0] PhaseLast  = 4'd8;
  localparam logic [PhaseW-1:0] PhaseDone  = 4'd9;

  typedef struct packed {
    logic [ThrW-1:0]  thr;
    logic [HoldW-1:0] nhold;
    logic [HoldW-1:0] ehold;
  } cfg_t;

  // divide by ten through reciprocal 0xCCCD / 2^19, exact for 16-bit values,
  // low nine bits of the quotient kept
  function automatic logic [ValW-1:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(16'hCCCD);
    return p[19 +: ValW];
  endfunction

endpackage

>>> hdl/rcsr_in_stage.sv
module rcsr_in_stage import rcsr_pkg::*; #(
  parameter int unsigned ItemW = 4 * WidthBitsDef + 1 + TimeW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [ItemW-1:0] item_i,
  input  logic             take_i,
  output logic             valid_o,
  output logic [ItemW-1:0] item_o
);

  logic             valid_q, valid_d;
  logic [ItemW-1:0] item_q;

  // slot frees when empty or when the held item moves on this cycle
  assign s_tready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_tready_o) valid_d = s_tvalid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) item_q <= item_i;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hdl/rcsr_cal_core.sv
module rcsr_cal_core import rcsr_pkg::*; #(
  parameter int unsigned WidthBits = WidthBitsDef,
  localparam int unsigned ItemW = 4 * WidthBits + 1 + TimeW,
  localparam int unsigned ResW  = PhaseW + 8 * WidthBits + 1 + SlotW + ValW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                fire_i,
  input  logic [ItemW-1:0]    item_i,
  output logic [ResW-1:0]     res_o
);

  cfg_t                 cfg_q;
  logic [WidthBits-1:0] neut_q [NumCh];
  logic [WidthBits-1:0] neut_d [NumCh];
  logic [WidthBits-1:0] bnd_q  [NumBnd];
  logic [WidthBits-1:0] bnd_d  [NumBnd];
  logic [PhaseW-1:0]    phase_q, phase_d;
  logic [TimeW-1:0]     mark_q, mark_d;

  logic [WidthBits-1:0] w    [NumCh];
  logic [WidthBits-1:0] dev  [NumCh];
  logic                 start;
  logic [TimeW-1:0]     now;
  logic [TimeW-1:0]     elapsed;
  logic                 moved, entered, hit;
  logic [SlotW-1:0]     bidx;
  logic [1:0]           ch;
  logic [WidthBits-1:0] sel;
  logic                 wr;
  logic [SlotW-1:0]     slot;
  logic [ValW-1:0]      val;

  // item unpacking and per-channel deviation from neutral
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      w[i]   = item_i[i*WidthBits +: WidthBits];
      dev[i] = (neut_q[i] > w[i]) ? (neut_q[i] - w[i]) : (w[i] - neut_q[i]);
    end
    start   = item_i[4*WidthBits];
    now     = item_i[4*WidthBits+1 +: TimeW];
    elapsed = now - mark_q;
    moved   = 1'b0;
    for (int i = 0; i < NumCh; i++) begin
      if (16'(dev[i]) > 16'(cfg_q.thr)) moved = 1'b1;
    end
  end

  // next state; a timer restarted in this item reads zero elapsed time
  always_comb begin
    phase_d = phase_q;
    mark_d  = mark_q;
    neut_d  = neut_q;
    bnd_d   = bnd_q;
    entered = 1'b0;
    hit     = 1'b0;
    bidx    = '0;
    ch      = '0;
    sel     = '0;
    wr      = 1'b0;
    slot    = '0;
    val     = '0;
    if (!start) begin
      phase_d = PhaseIdle;
    end else begin
      // wait for sticks at rest
      if (phase_q == PhaseIdle) begin
        if (moved) begin
          for (int i = 0; i < NumCh; i++) begin
            neut_d[i]     = w[i];
            bnd_d[2*i]    = w[i];
            bnd_d[2*i+1]  = w[i];
          end
          mark_d = now;
        end
        if (moved ? (cfg_q.nhold == '0) : (elapsed >= TimeW'(cfg_q.nhold))) begin
          phase_d = PhaseFirst;
          mark_d  = now;
          entered = 1'b1;
        end
      end
      // track one bound; odd phases a maximum, even phases a minimum
      if (phase_d >= PhaseFirst && phase_d <= PhaseLast) begin
        bidx = SlotW'(phase_d - PhaseFirst);
        ch   = bidx[2:1];
        sel  = bnd_d[bidx];
        hit  = bidx[0] ? (sel > w[ch]) : (sel < w[ch]);
        if (hit) begin
          bnd_d[bidx] = w[ch];
          sel         = w[ch];
          mark_d      = now;
        end
        if ((entered || hit) ? (cfg_q.ehold == '0)
                             : (elapsed >= TimeW'(cfg_q.ehold))) begin
          wr      = 1'b1;
          slot    = bidx;
          val     = div10(16'(sel));
          phase_d = phase_d + PhaseW'(1);
          mark_d  = (phase_d == PhaseDone) ? '0 : now;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr   <= NeutralThrRst;
      cfg_q.nhold <= NeutralHoldRst;
      cfg_q.ehold <= ExtremeHoldRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CfgNeutralThr:  cfg_q.thr   <= cfg_wdata_i[ThrW-1:0];
        CfgNeutralHold: cfg_q.nhold <= cfg_wdata_i[HoldW-1:0];
        CfgExtremeHold: cfg_q.ehold <= cfg_wdata_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // calibration state, updated once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseIdle;
      mark_q  <= '0;
      for (int i = 0; i < NumCh; i++) neut_q[i] <= '0;
      for (int i = 0; i < NumBnd; i++) bnd_q[i] <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      mark_q  <= mark_d;
      neut_q  <= neut_d;
      bnd_q   <= bnd_d;
    end
  end

  // result packing: phase, eight bounds, store write, slot, value
  always_comb begin
    res_o[PhaseW-1:0] = phase_d;
    for (int k = 0; k < NumBnd; k++) begin
      res_o[PhaseW + k*WidthBits +: WidthBits] = bnd_d[k];
    end
    res_o[PhaseW + 8*WidthBits]                 = wr;
    res_o[PhaseW + 8*WidthBits + 1 +: SlotW]    = slot;
    res_o[PhaseW + 8*WidthBits + 1 + SlotW +: ValW] = val;
  end

endmodule

>>> hdl/rcsr_out_stage.sv
module rcsr_out_stage import rcsr_pkg::*; #(
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [DataW-1:0] data_i,
  output logic             free_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [DataW-1:0] m_tdata_o
);

  logic             valid_q, valid_d;
  logic [DataW-1:0] data_q;

  // result register can take a new item when empty or being drained
  assign free_o = !valid_q || m_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (m_tready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= data_i;
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = data_q;

endmodule

>>> hdl/rc_stick_range_calibrator.sv
// an accepted item waits in the input register, and its result enters the result
// register when that is free; throughput: one item per cycle unless the result
// side stalls; each register holds one item; the calibration loop is combinational
// stalls: the input waits only while both registers hold items and the result waits
// reset: asynchronous, clears calibration state, bounds and valid flags, and
// returns the configuration registers to their defaults
module rc_stick_range_calibrator import rcsr_pkg::*; #(
  parameter int unsigned WidthBits = WidthBitsDef,
  localparam int unsigned ItemW    = 4 * WidthBits + 1 + TimeW,
  localparam int unsigned InDataW  = ((ItemW + 7) / 8) * 8,
  localparam int unsigned ResW     = PhaseW + 8 * WidthBits + 1 + SlotW + ValW,
  localparam int unsigned OutDataW = ((ResW + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // throttle_width, elevator_width, aileron_width, rudder_width,
  // start_request, now_ms
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  // phase, throttle_high, throttle_low, elevator_high, elevator_low,
  // aileron_high, aileron_low, rudder_high, rudder_low, store_write,
  // store_slot, store_value
  output logic [OutDataW-1:0] m_tdata_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic             in_valid;
  logic [ItemW-1:0] in_item;
  logic             out_free;
  logic             fire;
  logic [ResW-1:0]  res;

  // an item moves from input register to result register when the latter is free
  assign fire = in_valid && out_free;

  rcsr_in_stage #(
    .ItemW (ItemW)
  ) u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .item_i     (s_tdata_i[ItemW-1:0]),
    .take_i     (out_free),
    .valid_o    (in_valid),
    .item_o     (in_item)
  );

  rcsr_cal_core #(
    .WidthBits (WidthBits)
  ) u_cal_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (in_item),
    .res_o       (res)
  );

  rcsr_out_stage #(
    .DataW (OutDataW)
  ) u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .data_i     (OutDataW'(res)),
    .free_o     (out_free),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

endmodule

>>> hdl/rcsr_checker.sv
module rcsr_checker import rcsr_pkg::*; #(
  parameter int unsigned WidthBits = WidthBitsDef,
  localparam int unsigned ResW     = PhaseW + 8 * WidthBits + 1 + SlotW + ValW,
  localparam int unsigned OutDataW = ((ResW + 7) / 8) * 8,
  localparam int unsigned WrPos    = PhaseW + 8 * WidthBits
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic [OutDataW-1:0] m_tdata_o,
  input logic                m_tvalid_o,
  input logic                m_tready_i
);

  logic [PhaseW-1:0] phase;
  logic              wr;
  logic [SlotW-1:0]  slot;
  logic [ValW-1:0]   val;

  assign phase = m_tdata_o[PhaseW-1:0];
  assign wr    = m_tdata_o[WrPos];
  assign slot  = m_tdata_o[WrPos + 1 +: SlotW];
  assign val   = m_tdata_o[WrPos + 1 + SlotW +: ValW];

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result item changed while stalled");

  // no store write leaves slot and value clear
  a_no_wr_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !wr |-> slot == '0 && val == '0)
    else $error("slot or value set without store write");

  // phase never goes past done
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> phase <= PhaseDone)
    else $error("phase beyond done");

  // a store write ends the phase that tracked its slot
  a_wr_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && wr |-> phase >= (PhaseFirst + PhaseW'(1))
                         && SlotW'(phase - (PhaseFirst + PhaseW'(1))) == slot)
    else $error("store slot does not match finished phase");

endmodule

bind rc_stick_range_calibrator rcsr_checker #(.WidthBits(WidthBits)) u_rcsr_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rcsr_pkg::*;

  localparam int unsigned WB         = WidthBitsDef;
  localparam int unsigned InW        = ((4 * WB + 1 + TimeW + 7) / 8) * 8;
  localparam int unsigned OutW       = ((PhaseW + NumBnd * WB + 1 + SlotW + ValW + 7) / 8) * 8;
  localparam int unsigned WrPos      = PhaseW + NumBnd * WB;
  localparam int unsigned SlotPos    = WrPos + 1;
  localparam int unsigned ValPos     = SlotPos + SlotW;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ItemsPerSetting = 275;
  localparam int unsigned NumSettings     = 6;
  localparam int unsigned HoldOffCycles   = 300;
  localparam logic [WB-1:0] WidthMax = '1;

  // bound slots, in the order of the result fields
  typedef enum logic [SlotW-1:0] {
    SlotThrHigh, SlotThrLow, SlotEleHigh, SlotEleLow,
    SlotAilHigh, SlotAilLow, SlotRudHigh, SlotRudLow
  } bound_slot_e;

  typedef struct packed {
    logic [WB-1:0]    throttle;
    logic [WB-1:0]    elevator;
    logic [WB-1:0]    aileron;
    logic [WB-1:0]    rudder;
    logic             start;
    logic [TimeW-1:0] now;
  } stick_item_t;

  typedef struct packed {
    logic [PhaseW-1:0]         phase;
    logic [NumBnd-1:0][WB-1:0] bnd;
    logic                      wr;
    logic [SlotW-1:0]          slot;
    logic [ValW-1:0]           val;
  } cal_result_t;

  typedef struct {
    bit                is_setting;
    logic [ThrW-1:0]   thr;
    logic [HoldW-1:0]  nhold;
    logic [HoldW-1:0]  ehold;
    stick_item_t       item;
    bit                typed;
    logic [PhaseW-1:0] phase;
    logic              wr;
    logic [SlotW-1:0]  slot;
    logic [ValW-1:0]   val;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  // throttle_width, elevator_width, aileron_width, rudder_width, start_request, now_ms
  logic [InW-1:0]      s_tdata_i   = '0;
  logic                s_tvalid_i  = 1'b0;
  logic                s_tready_o;
  // phase, 8 bounds (throttle high .. rudder low), store_write, store_slot, store_value
  logic [OutW-1:0]     m_tdata_o;
  logic                m_tvalid_o;
  logic                m_tready_i  = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr_i  = CfgNeutralThr;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  rc_stick_range_calibrator #(
    .WidthBits(WB)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tdata_o  (m_tdata_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // calibration state as the block should hold it
  logic [ThrW-1:0]   cfg_thr   = NeutralThrRst;
  logic [HoldW-1:0]  cfg_nhold = NeutralHoldRst;
  logic [HoldW-1:0]  cfg_ehold = ExtremeHoldRst;
  logic [WB-1:0]     cal_neutral [NumCh];
  logic [WB-1:0]     cal_bound [NumBnd];
  logic [PhaseW-1:0] cal_phase = PhaseIdle;
  logic [TimeW-1:0]  cal_mark  = '0;

  cal_result_t pending_results [$];
  stim_row_t   stim_rows [$];
  logic [TimeW-1:0] stim_now = '0;

  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned items_sent    = 0;
  int unsigned store_writes  = 0;
  int unsigned runs_done     = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count   = 0;
  int unsigned gap_pct       = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_left     = 0;
  bit          holdoff_pending = 1'b0;

  // random register settings and the idling that goes with each
  int unsigned set_thr   [NumSettings] = '{3, 0, 4095, 20, 7, 2};
  int unsigned set_nhold [NumSettings] = '{40, 0, 65535, 100, 10, 300};
  int unsigned set_ehold [NumSettings] = '{30, 0, 65535, 60, 5, 200};
  int unsigned set_gap   [NumSettings] = '{0, 58, 0, 33, 0, 33};
  int unsigned set_stall [NumSettings] = '{0, 0, 58, 33, 0, 33};

  string bound_name [NumBnd] = '{"throttle_high", "throttle_low", "elevator_high",
                                 "elevator_low", "aileron_high", "aileron_low",
                                 "rudder_high", "rudder_low"};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < NumCh; i++) cal_neutral[i] = '0;
    for (int i = 0; i < NumBnd; i++) cal_bound[i] = '0;
  end

  // one calibration step per accepted item
  function automatic cal_result_t advance_calibration(stick_item_t it);
    cal_result_t   res;
    logic [WB-1:0] w [NumCh];
    logic [WB-1:0] dev;
    logic          moved;
    int unsigned   b;
    int unsigned   ch;
    res  = '0;
    w[0] = it.throttle;
    w[1] = it.elevator;
    w[2] = it.aileron;
    w[3] = it.rudder;
    if (!it.start) begin
      cal_phase = PhaseIdle;
    end else begin
      // waiting for the sticks to rest
      if (cal_phase == PhaseIdle) begin
        moved = 1'b0;
        for (int i = 0; i < NumCh; i++) begin
          dev = (cal_neutral[i] > w[i]) ? cal_neutral[i] - w[i] : w[i] - cal_neutral[i];
          if (dev > cfg_thr) moved = 1'b1;
        end
        if (moved) begin
          for (int i = 0; i < NumCh; i++) begin
            cal_neutral[i]     = w[i];
            cal_bound[2 * i]   = w[i];
            cal_bound[2 * i + 1] = w[i];
          end
          cal_mark = it.now;
        end
        if (it.now - cal_mark >= TimeW'(cfg_nhold)) begin
          cal_phase = PhaseFirst;
          cal_mark  = it.now;
        end
      end
      // tracking one extreme, also in the item that entered the phase
      if (cal_phase >= PhaseFirst && cal_phase <= PhaseLast) begin
        b  = cal_phase - PhaseFirst;
        ch = b / 2;
        if ((b % 2 == 0) ? (cal_bound[b] < w[ch]) : (cal_bound[b] > w[ch])) begin
          cal_bound[b] = w[ch];
          cal_mark     = it.now;
        end
        if (it.now - cal_mark >= TimeW'(cfg_ehold)) begin
          res.wr    = 1'b1;
          res.slot  = SlotW'(b);
          res.val   = ValW'(cal_bound[b] / 10);
          cal_phase = cal_phase + 1'b1;
          cal_mark  = (cal_phase == PhaseDone) ? '0 : it.now;
        end
      end
    end
    res.phase = cal_phase;
    for (int i = 0; i < NumBnd; i++) res.bnd[i] = cal_bound[i];
    return res;
  endfunction

  function automatic logic [InW-1:0] pack_item(stick_item_t it);
    return InW'({it.now, it.start, it.rudder, it.aileron, it.elevator, it.throttle});
  endfunction

  // a width that still counts as rest around a neutral
  function automatic logic [WB-1:0] near_rest(logic [WB-1:0] center);
    int span;
    int v;
    span = (cfg_thr < 40) ? int'(cfg_thr) : 40;
    v = int'(center) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > int'(WidthMax)) v = int'(WidthMax);
    return WB'(v);
  endfunction

  // mostly well-formed calibration sticks, some noise and restarts
  function automatic stick_item_t next_random_item(int unsigned step_max);
    stick_item_t   it;
    logic [WB-1:0] w [NumCh];
    int unsigned   pick;
    int unsigned   b;
    int unsigned   ch;
    int unsigned   bound;
    int unsigned   lim;
    pick = $urandom_range(0, 99);
    for (int i = 0; i < NumCh; i++) w[i] = near_rest(cal_neutral[i]);
    if ($urandom_range(0, 49) == 0) stim_now = $urandom();
    else stim_now = stim_now + $urandom_range(0, step_max);
    it.start = 1'b1;
    if (pick < 2) begin
      for (int i = 0; i < NumCh; i++) w[i] = WB'($urandom());
      it.start = 1'($urandom_range(0, 1));
    end else if (pick == 2) begin
      it.start = 1'b0;
    end else if (cal_phase == PhaseIdle) begin
      if (pick < 9) begin
        for (int i = 0; i < NumCh; i++) w[i] = WB'($urandom());
      end
    end else if (cal_phase <= PhaseLast) begin
      b     = cal_phase - PhaseFirst;
      ch    = b / 2;
      bound = cal_bound[b];
      if (b % 2 == 0) begin
        lim = (bound + 300 > WidthMax) ? WidthMax : bound + 300;
        if (pick < 18 && bound < WidthMax) w[ch] = WB'($urandom_range(bound + 1, lim));
        else w[ch] = WB'($urandom_range(bound > 200 ? bound - 200 : 0, bound));
      end else begin
        lim = (bound + 200 > WidthMax) ? WidthMax : bound + 200;
        if (pick < 18 && bound > 0) w[ch] = WB'($urandom_range(bound > 300 ? bound - 300 : 0,
                                                              bound - 1));
        else w[ch] = WB'($urandom_range(bound, lim));
      end
    end else if (pick < 23) begin
      it.start = 1'b0;
    end
    it.throttle = w[0];
    it.elevator = w[1];
    it.aileron  = w[2];
    it.rudder   = w[3];
    it.now      = stim_now;
    return it;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("[%0t] result %0d: %s expected %0d got %0d", $time, results_seen, what, want, got);
    mismatches++;
  endtask

  task automatic compare_result(cal_result_t want, cal_result_t got);
    if (got.phase !== want.phase) report_mismatch("phase", want.phase, got.phase);
    for (int i = 0; i < NumBnd; i++) begin
      if (got.bnd[i] !== want.bnd[i]) report_mismatch(bound_name[i], want.bnd[i], got.bnd[i]);
    end
    if (got.wr !== want.wr) report_mismatch("store_write", want.wr, got.wr);
    if (got.slot !== want.slot) report_mismatch("store_slot", want.slot, got.slot);
    if (got.val !== want.val) report_mismatch("store_value", want.val, got.val);
  endtask

  // result side: check each accepted item, then pick the next ready
  always @(posedge clk_i) begin : result_check
    cal_result_t got;
    if (m_tvalid_o && m_tready_i) begin
      got.phase = m_tdata_o[PhaseW-1:0];
      for (int i = 0; i < NumBnd; i++) got.bnd[i] = m_tdata_o[PhaseW + WB * i +: WB];
      got.wr   = m_tdata_o[WrPos];
      got.slot = m_tdata_o[SlotPos +: SlotW];
      got.val  = m_tdata_o[ValPos +: ValW];
      if (pending_results.size() == 0) begin
        report_mismatch("result item with nothing expected", 0, 0);
      end else begin
        compare_result(pending_results.pop_front(), got);
      end
      results_seen++;
    end
    if (holdoff_pending) begin
      hold_left       = HoldOffCycles;
      holdoff_pending = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("rc_stick_range_calibrator: mismatch");
      $finish;
    end
  end

  // offer one item and predict its result once accepted
  task automatic send_item(stick_item_t it, bit typed, cal_result_t typed_res);
    cal_result_t want;
    s_tdata_i  <= pack_item(it);
    s_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_tready_o);
    want = advance_calibration(it);
    if (typed) begin
      want.phase = typed_res.phase;
      want.wr    = typed_res.wr;
      want.slot  = typed_res.slot;
      want.val   = typed_res.val;
    end
    pending_results.push_back(want);
    items_sent++;
    if (want.wr) store_writes++;
    if (want.wr && want.phase == PhaseDone) runs_done++;
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // registers are only written with the block idle
  task automatic apply_setting(logic [ThrW-1:0] thr, logic [HoldW-1:0] nhold,
                               logic [HoldW-1:0] ehold);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CfgNeutralThr;
    cfg_wdata_i <= CfgDataW'(thr);
    @(posedge clk_i);
    cfg_thr      = thr;
    cfg_addr_i  <= CfgNeutralHold;
    cfg_wdata_i <= nhold;
    @(posedge clk_i);
    cfg_nhold    = nhold;
    cfg_addr_i  <= CfgExtremeHold;
    cfg_wdata_i <= ehold;
    @(posedge clk_i);
    cfg_ehold    = ehold;
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  function automatic void add_setting(logic [ThrW-1:0] thr, logic [HoldW-1:0] nhold,
                                      logic [HoldW-1:0] ehold);
    stim_row_t row;
    row            = '{default: '0};
    row.is_setting = 1'b1;
    row.thr        = thr;
    row.nhold      = nhold;
    row.ehold      = ehold;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_row(logic [WB-1:0] thr_w, logic [WB-1:0] ele_w,
                                  logic [WB-1:0] ail_w, logic [WB-1:0] rud_w,
                                  logic start, logic [TimeW-1:0] now, bit typed,
                                  logic [PhaseW-1:0] phase, logic wr,
                                  logic [SlotW-1:0] slot, logic [ValW-1:0] val);
    stim_row_t row;
    row               = '{default: '0};
    row.item.throttle = thr_w;
    row.item.elevator = ele_w;
    row.item.aileron  = ail_w;
    row.item.rudder   = rud_w;
    row.item.start    = start;
    row.item.now      = now;
    row.typed         = typed;
    row.phase         = phase;
    row.wr            = wr;
    row.slot          = slot;
    row.val           = val;
    stim_rows.push_back(row);
  endfunction

  initial begin : stimulus
    cal_result_t typed_res;
    stick_item_t it;
    int unsigned step_max;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset register values: rest, hold times, extremes
    add_row(0, 0, 0, 0, 0, 0, 1, PhaseIdle, 0, 0, 0);
    add_row(1500, 1500, 1500, 1500, 1, 100, 1, PhaseIdle, 0, 0, 0);
    // deviation exactly at the threshold, one ms short of the rest time
    add_row(1503, 1497, 1503, 1497, 1, 10099, 1, PhaseIdle, 0, 0, 0);
    add_row(1500, 1500, 1500, 1500, 1, 10100, 1, PhaseFirst, 0, 0, 0);
    add_row(WidthMax, 1500, 1500, 1500, 1, 10200, 1, PhaseFirst, 0, 0, 0);
    add_row(0, 1500, 1500, 1500, 1, 17199, 1, PhaseFirst, 0, 0, 0);
    add_row(0, 1500, 1500, 1500, 1, 17200, 1, PhaseFirst + 1, 1, SlotThrHigh, 409);
    add_row(0, 1500, 1500, 1500, 1, 17300, 1, PhaseFirst + 1, 0, 0, 0);
    add_row(0, 1500, 1500, 1500, 1, 24300, 1, PhaseFirst + 2, 1, SlotThrLow, 0);
    // timestamp wrapping past zero
    add_row(1500, WidthMax, 1500, 1500, 1, 32'hFFFF_FF00, 1, PhaseFirst + 2, 0, 0, 0);
    add_row(1500, 2000, 1500, 1500, 1, 32'h0000_1B00, 1, PhaseFirst + 3, 1, SlotEleHigh, 409);
    // start low drops back to idle, bounds kept
    add_row(1500, 2000, 1500, 1500, 0, 32'h0000_1C00, 1, PhaseIdle, 0, 0, 0);
    // zero hold times: every item closes a phase, through to done
    add_setting(WidthMax, 0, 0);
    add_row(0, 0, 0, 0, 1, 5000, 1, PhaseFirst + 1, 1, SlotThrHigh, 409);
    add_row(WidthMax, WidthMax, WidthMax, WidthMax, 1, 5001, 1, PhaseFirst + 2, 1, SlotThrLow, 0);
    add_row(WidthMax, WidthMax, WidthMax, WidthMax, 1, 5002, 1, PhaseFirst + 3, 1,
            SlotEleHigh, 409);
    add_row(WidthMax, WidthMax, WidthMax, WidthMax, 1, 5003, 1, PhaseFirst + 4, 1,
            SlotEleLow, 150);
    add_row(WidthMax, WidthMax, WidthMax, WidthMax, 1, 5004, 1, PhaseFirst + 5, 1,
            SlotAilHigh, 409);
    add_row(0, 0, 0, 0, 1, 5005, 1, PhaseFirst + 6, 1, SlotAilLow, 0);
    add_row(0, 0, 0, 0, 1, 5006, 1, PhaseLast, 1, SlotRudHigh, 150);
    add_row(0, 0, 0, 0, 1, 5007, 1, PhaseDone, 1, SlotRudLow, 0);
    // done holds everything
    add_row(123, 456, 789, 1011, 1, 9999, 1, PhaseDone, 0, 0, 0);
    add_row(123, 456, 789, 1011, 0, 10000, 1, PhaseIdle, 0, 0, 0);
    // zero threshold: any single step recaptures
    add_setting(0, 1, 1);
    add_row(1, 0, 0, 0, 1, 7, 1, PhaseIdle, 0, 0, 0);
    add_row(1, 0, 0, 0, 1, 8, 1, PhaseFirst, 0, 0, 0);
    add_row(1, 0, 0, 0, 1, 9, 1, PhaseFirst + 1, 1, SlotThrHigh, 0);

    // walk the directed table
    foreach (stim_rows[r]) begin
      if (stim_rows[r].is_setting) begin
        apply_setting(stim_rows[r].thr, stim_rows[r].nhold, stim_rows[r].ehold);
      end else begin
        typed_res       = '0;
        typed_res.phase = stim_rows[r].phase;
        typed_res.wr    = stim_rows[r].wr;
        typed_res.slot  = stim_rows[r].slot;
        typed_res.val   = stim_rows[r].val;
        send_item(stim_rows[r].item, stim_rows[r].typed, typed_res);
      end
    end

    // random part, one register setting and idling style at a time
    for (int s = 0; s < NumSettings; s++) begin
      apply_setting(ThrW'(set_thr[s]), HoldW'(set_nhold[s]), HoldW'(set_ehold[s]));
      gap_pct   = set_gap[s];
      stall_pct = set_stall[s];
      step_max  = ((set_nhold[s] > set_ehold[s]) ? set_nhold[s] : set_ehold[s]) / 2 + 2;
      for (int n = 0; n < ItemsPerSetting; n++) begin
        it = next_random_item(step_max);
        send_item(it, 1'b0, '0);
        // long receiver hold-off while items keep coming
        if (s == 2 && n == 60) holdoff_pending = 1'b1;
        // sender pause until every result is back
        if (s == 4 && n == 140) wait_drained();
        maybe_gap();
      end
    end

    wait_drained();
    $display("covered %0d items over %0d register settings: %0d store writes, %0d full runs",
             items_sent, settings_used, store_writes, runs_done);
    $display("checked %0d result items, %0d field mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("rc_stick_range_calibrator: match");
    end else begin
      $display("rc_stick_range_calibrator: mismatch");
    end
    $finish;
  end

endmodule
